// ===== design/tbat_pkg.sv =====
package tbat_pkg;
   localparam int QUEUE_DEPTH = 64;
   localparam int IDX_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = IDX_W + 1;

   localparam logic [2:0] ST_OK        = 3'd0;
   localparam logic [2:0] ST_BUF_FULL  = 3'd1;
   localparam logic [2:0] ST_EMPTY     = 3'd2;
   localparam logic [2:0] ST_NOT_FOUND = 3'd3;
   localparam logic [2:0] ST_STALE     = 3'd4;
   localparam logic [2:0] ST_Q_FULL    = 3'd5;

   localparam logic [1:0] ACT_ADD  = 2'd0;
   localparam logic [1:0] ACT_SEND = 2'd1;
   localparam logic [1:0] ACT_ACK  = 2'd2;
   localparam logic [1:0] ACT_RETX = 2'd3;

   localparam logic [1:0] KIND_NONE     = 2'd0;
   localparam logic [1:0] KIND_IN_ORDER = 2'd1;
   localparam logic [1:0] KIND_OUT_ORD  = 2'd2;

   typedef struct packed {
      logic        shift;
      logic        load;
      logic [31:0] data;
   } cell_ctl_type;
endpackage

// ===== design/tbat_cell.sv =====
module tbat_cell
   import tbat_pkg::*;
(
   input  logic         clock,
   input  cell_ctl_type ctl,
   input  logic [31:0]  nbr_id,
   output logic [31:0]  id
);
   logic [31:0] id_ff, id_in;

   always_comb begin
      id_in = id_ff;
      if (ctl.load) begin
         id_in = ctl.data;
      end else if (ctl.shift) begin
         id_in = nbr_id;
      end
   end

   always_ff @(posedge clock) begin
      id_ff <= id_in;
   end

   assign id = id_ff;
endmodule

// ===== design/tx_buffer_ack_tracker_unit.sv =====
// Transmit buffer with selective-ack retransmit queue. Pulse start while busy is low to
// issue one item; exactly one result appears for one cycle with rsp_valid and must be
// taken then, since the receiver cannot stall. Add, send, in-order or stale ack and
// retransmit pass through S_EXEC, S_SETTLE and S_REPORT. An out-of-order ack walks the
// sent queue, held in a chain of cells that rotates one entry per cycle, twice (count
// pass, then move pass, with S_CHECK between); it skips the move pass when the entries
// it would move do not fit in the retransmit queue. The csr register may be written at
// any time the block is idle.
module tx_buffer_ack_tracker_unit
   import tbat_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [1:0]  req_action,
   input  logic [15:0] req_packet_bytes,
   input  logic [31:0] req_ack_id,
   output logic        rsp_valid,
   output logic [2:0]  rsp_status,
   output logic [31:0] rsp_packet_id,
   output logic [1:0]  rsp_ack_kind,
   output logic [6:0]  rsp_moved_count,
   output logic [31:0] rsp_pending_front_id,
   output logic [31:0] rsp_sent_front_id,
   output logic        rsp_retx_waiting,
   output logic [23:0] rsp_buffered_total,
   input  logic        csr_we,
   input  logic [23:0] csr_wdata
);
   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_EXEC   = 3'd1;
   localparam logic [2:0] S_WALK   = 3'd2;
   localparam logic [2:0] S_CHECK  = 3'd3;
   localparam logic [2:0] S_SETTLE = 3'd4;
   localparam logic [2:0] S_REPORT = 3'd5;

   logic [2:0]  state_ff, state_in;
   logic [23:0] budget_ff;
   logic [1:0]  act_ff;
   logic [15:0] pbytes_ff;
   logic [31:0] ack_ff;
   logic [31:0] seq_ff, seq_in;
   logic [23:0] pbuf_ff, pbuf_in;
   logic [IDX_W-1:0] p_head_ff, p_head_in, r_head_ff, r_head_in;
   logic [CNT_W-1:0] p_cnt_ff, p_cnt_in, s_cnt_ff, s_cnt_in, r_cnt_ff, r_cnt_in;
   logic [CNT_W-1:0] i_ff, i_in, n_ff, n_in, kept_ff, kept_in, need_ff, need_in;
   logic [CNT_W-1:0] moved_ff, moved_in;
   logic commit_ff, commit_in, found_ff, found_in;
   logic [2:0]  status_ff, status_in;
   logic [31:0] pid_ff, pid_in;
   logic [1:0]  kind_ff, kind_in;

   logic [31:0] pid_mem [QUEUE_DEPTH];
   logic [15:0] psz_mem [QUEUE_DEPTH];
   logic [31:0] rid_mem [QUEUE_DEPTH];
   logic [31:0] p_rd_ff, r_rd_ff;
   logic [15:0] psz_rd_ff;
   logic p_we, r_we;
   logic [IDX_W-1:0] p_wa, r_wa;
   logic [31:0] r_wd;

   logic [31:0] cell_id [QUEUE_DEPTH];
   cell_ctl_type ctl [QUEUE_DEPTH];
   logic shift;
   logic ld_en;
   logic [CNT_W-1:0] ld_pos;
   logic [31:0] ld_data;

   logic [31:0] head_id;
   logic [24:0] add_sum;
   logic [CNT_W:0] retx_need;

   assign head_id   = cell_id[0];
   assign add_sum   = {1'b0, pbuf_ff} + {9'd0, pbytes_ff};
   assign retx_need = {1'b0, r_cnt_ff} + {1'b0, need_ff};
   assign p_wa      = p_head_ff + p_cnt_ff[IDX_W-1:0];
   assign r_wa      = r_head_ff + r_cnt_ff[IDX_W-1:0];

   always_comb begin
      state_in  = state_ff;
      seq_in    = seq_ff;
      pbuf_in   = pbuf_ff;
      p_head_in = p_head_ff;
      r_head_in = r_head_ff;
      p_cnt_in  = p_cnt_ff;
      s_cnt_in  = s_cnt_ff;
      r_cnt_in  = r_cnt_ff;
      i_in      = i_ff;
      n_in      = n_ff;
      kept_in   = kept_ff;
      need_in   = need_ff;
      moved_in  = moved_ff;
      commit_in = commit_ff;
      found_in  = found_ff;
      status_in = status_ff;
      pid_in    = pid_ff;
      kind_in   = kind_ff;
      p_we      = 1'b0;
      r_we      = 1'b0;
      r_wd      = head_id;
      shift     = 1'b0;
      ld_en     = 1'b0;
      ld_pos    = s_cnt_ff;
      ld_data   = p_rd_ff;
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               state_in  = S_EXEC;
               status_in = ST_OK;
               pid_in    = '0;
               kind_in   = KIND_NONE;
               moved_in  = '0;
            end
         end
         S_EXEC: begin
            state_in = S_SETTLE;
            case (act_ff)
               ACT_ADD: begin
                  if (add_sum > {1'b0, budget_ff}) begin
                     status_in = ST_BUF_FULL;
                  end else if (p_cnt_ff == CNT_W'(QUEUE_DEPTH)) begin
                     status_in = ST_Q_FULL;
                  end else begin
                     seq_in   = seq_ff + 32'd1;
                     p_we     = 1'b1;
                     p_cnt_in = p_cnt_ff + 1'b1;
                     pbuf_in  = add_sum[23:0];
                     pid_in   = seq_ff + 32'd1;
                  end
               end
               ACT_SEND: begin
                  if (p_cnt_ff == '0) begin
                     status_in = ST_EMPTY;
                  end else if (s_cnt_ff == CNT_W'(QUEUE_DEPTH)) begin
                     status_in = ST_Q_FULL;
                  end else begin
                     pid_in    = p_rd_ff;
                     pbuf_in   = pbuf_ff - {8'd0, psz_rd_ff};
                     p_head_in = p_head_ff + 1'b1;
                     p_cnt_in  = p_cnt_ff - 1'b1;
                     ld_en     = 1'b1;
                     s_cnt_in  = s_cnt_ff + 1'b1;
                  end
               end
               ACT_ACK: begin
                  if (s_cnt_ff == '0) begin
                     status_in = ST_EMPTY;
                  end else begin
                     pid_in = head_id;
                     if (ack_ff == head_id) begin
                        kind_in  = KIND_IN_ORDER;
                        shift    = 1'b1;
                        s_cnt_in = s_cnt_ff - 1'b1;
                     end else if (ack_ff < head_id) begin
                        kind_in   = KIND_OUT_ORD;
                        status_in = ST_STALE;
                     end else begin
                        kind_in   = KIND_OUT_ORD;
                        state_in  = S_WALK;
                        n_in      = s_cnt_ff;
                        i_in      = '0;
                        kept_in   = '0;
                        need_in   = '0;
                        commit_in = 1'b0;
                        found_in  = 1'b0;
                     end
                  end
               end
               default: begin
                  if (r_cnt_ff == '0) begin
                     status_in = ST_EMPTY;
                  end else begin
                     pid_in    = r_rd_ff;
                     r_head_in = r_head_ff + 1'b1;
                     r_cnt_in  = r_cnt_ff - 1'b1;
                  end
               end
            endcase
         end
         S_WALK: begin
            shift   = 1'b1;
            ld_pos  = n_ff - 1'b1 - i_ff + kept_ff;
            ld_data = head_id;
            if (!commit_ff) begin
               ld_en   = 1'b1;
               kept_in = kept_ff + 1'b1;
               if (head_id < ack_ff) begin
                  need_in = need_ff + 1'b1;
               end
            end else if (head_id == ack_ff) begin
               found_in = 1'b1;
            end else if (head_id < ack_ff) begin
               r_we     = 1'b1;
               r_cnt_in = r_cnt_ff + 1'b1;
               moved_in = moved_ff + 1'b1;
            end else begin
               ld_en   = 1'b1;
               kept_in = kept_ff + 1'b1;
            end
            i_in = i_ff + 1'b1;
            if (i_ff == n_ff - 1'b1) begin
               if (!commit_ff) begin
                  state_in = S_CHECK;
               end else begin
                  state_in = S_SETTLE;
                  s_cnt_in = kept_in;
                  if (!(found_ff || head_id == ack_ff)) begin
                     status_in = ST_NOT_FOUND;
                  end
               end
            end
         end
         S_CHECK: begin
            if (retx_need > (CNT_W+1)'(QUEUE_DEPTH)) begin
               status_in = ST_Q_FULL;
               state_in  = S_SETTLE;
            end else begin
               commit_in = 1'b1;
               i_in      = '0;
               kept_in   = '0;
               state_in  = S_WALK;
            end
         end
         S_SETTLE: begin
            state_in = S_REPORT;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         budget_ff <= '0;
         seq_ff    <= '0;
         pbuf_ff   <= '0;
         p_head_ff <= '0;
         r_head_ff <= '0;
         p_cnt_ff  <= '0;
         s_cnt_ff  <= '0;
         r_cnt_ff  <= '0;
      end else begin
         state_ff  <= state_in;
         if (csr_we) begin
            budget_ff <= csr_wdata;
         end
         seq_ff    <= seq_in;
         pbuf_ff   <= pbuf_in;
         p_head_ff <= p_head_in;
         r_head_ff <= r_head_in;
         p_cnt_ff  <= p_cnt_in;
         s_cnt_ff  <= s_cnt_in;
         r_cnt_ff  <= r_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == S_IDLE && start) begin
         act_ff    <= req_action;
         pbytes_ff <= req_packet_bytes;
         ack_ff    <= req_ack_id;
      end
      i_ff      <= i_in;
      n_ff      <= n_in;
      kept_ff   <= kept_in;
      need_ff   <= need_in;
      moved_ff  <= moved_in;
      commit_ff <= commit_in;
      found_ff  <= found_in;
      status_ff <= status_in;
      pid_ff    <= pid_in;
      kind_ff   <= kind_in;
   end

   always_ff @(posedge clock) begin
      if (p_we) begin
         pid_mem[p_wa] <= seq_in;
         psz_mem[p_wa] <= pbytes_ff;
      end
      p_rd_ff   <= pid_mem[p_head_ff];
      psz_rd_ff <= psz_mem[p_head_ff];
   end

   always_ff @(posedge clock) begin
      if (r_we) begin
         rid_mem[r_wa] <= r_wd;
      end
      r_rd_ff <= rid_mem[r_head_ff];
   end

   for (genvar k = 0; k < QUEUE_DEPTH; k++) begin : g_chain
      logic [31:0] nbr;
      assign ctl[k].shift = shift;
      assign ctl[k].load  = ld_en && (ld_pos[IDX_W-1:0] == IDX_W'(k));
      assign ctl[k].data  = ld_data;
      if (k == QUEUE_DEPTH - 1) begin : g_last
         assign nbr = '0;
      end else begin : g_mid
         assign nbr = cell_id[k+1];
      end
      tbat_cell u_cell (
         .clock  (clock),
         .ctl    (ctl[k]),
         .nbr_id (nbr),
         .id     (cell_id[k])
      );
   end

   assign busy                 = (state_ff != S_IDLE);
   assign rsp_valid            = (state_ff == S_REPORT);
   assign rsp_status           = status_ff;
   assign rsp_packet_id        = pid_ff;
   assign rsp_ack_kind         = kind_ff;
   assign rsp_moved_count      = 7'(moved_ff);
   assign rsp_pending_front_id = (p_cnt_ff == '0) ? 32'd0 : p_rd_ff;
   assign rsp_sent_front_id    = (s_cnt_ff == '0) ? 32'd0 : head_id;
   assign rsp_retx_waiting     = (r_cnt_ff != '0);
   assign rsp_buffered_total   = pbuf_ff;
endmodule

// ===== bench/tb_tx_buffer_ack_tracker_unit.sv =====
`timescale 1ns / 100ps

module tb_tx_buffer_ack_tracker_unit;
   import tbat_pkg::*;

   typedef struct packed {
      logic [2:0]  status;
      logic [31:0] packet_id;
      logic [1:0]  ack_kind;
      logic [6:0]  moved_count;
      logic [31:0] pending_front_id;
      logic [31:0] sent_front_id;
      logic        retx_waiting;
      logic [23:0] buffered_total;
   } outcome_t;

   class tracker_board;
      logic [23:0] budget;
      logic [31:0] seq_no;
      logic [23:0] held_bytes;
      logic [31:0] pend_ids[$];
      logic [15:0] pend_sizes[$];
      logic [31:0] sent_ids[$];
      logic [31:0] retx_ids[$];
      outcome_t    awaited[$];
      int          errors;
      int          checked;
      int          kind_seen[8];

      function new();
         budget = 0;
         seq_no = 0;
         held_bytes = 0;
         errors = 0;
         checked = 0;
      endfunction

      function void note_item(logic [1:0] act, logic [15:0] nbytes, logic [31:0] ack);
         outcome_t o;
         int need;
         logic [31:0] keep[$];
         logic found;
         o = '0;
         o.status = ST_OK;
         o.ack_kind = KIND_NONE;
         case (act)
            ACT_ADD: begin
               if ({8'd0, nbytes} + {8'd0, held_bytes} > {8'd0, budget}) begin
                  o.status = ST_BUF_FULL;
               end else if (pend_ids.size() >= QUEUE_DEPTH) begin
                  o.status = ST_Q_FULL;
               end else begin
                  seq_no = seq_no + 1;
                  pend_ids.push_back(seq_no);
                  pend_sizes.push_back(nbytes);
                  held_bytes = held_bytes + nbytes;
                  o.packet_id = seq_no;
               end
            end
            ACT_SEND: begin
               if (pend_ids.size() == 0) begin
                  o.status = ST_EMPTY;
               end else if (sent_ids.size() >= QUEUE_DEPTH) begin
                  o.status = ST_Q_FULL;
               end else begin
                  o.packet_id = pend_ids.pop_front();
                  held_bytes = held_bytes - pend_sizes.pop_front();
                  sent_ids.push_back(o.packet_id);
               end
            end
            ACT_ACK: begin
               if (sent_ids.size() == 0) begin
                  o.status = ST_EMPTY;
               end else begin
                  o.packet_id = sent_ids[0];
                  if (ack == sent_ids[0]) begin
                     o.ack_kind = KIND_IN_ORDER;
                     void'(sent_ids.pop_front());
                  end else if (ack < sent_ids[0]) begin
                     o.ack_kind = KIND_OUT_ORD;
                     o.status = ST_STALE;
                  end else begin
                     o.ack_kind = KIND_OUT_ORD;
                     need = 0;
                     foreach (sent_ids[i]) if (sent_ids[i] < ack) need++;
                     if (retx_ids.size() + need > QUEUE_DEPTH) begin
                        o.status = ST_Q_FULL;
                     end else begin
                        found = 0;
                        foreach (sent_ids[i]) begin
                           if (sent_ids[i] == ack) found = 1;
                           else if (sent_ids[i] < ack) begin
                              retx_ids.push_back(sent_ids[i]);
                              o.moved_count++;
                           end else keep.push_back(sent_ids[i]);
                        end
                        sent_ids = keep;
                        if (!found) o.status = ST_NOT_FOUND;
                     end
                  end
               end
            end
            default: begin
               if (retx_ids.size() == 0) o.status = ST_EMPTY;
               else o.packet_id = retx_ids.pop_front();
            end
         endcase
         o.pending_front_id = pend_ids.size() ? pend_ids[0] : 0;
         o.sent_front_id = sent_ids.size() ? sent_ids[0] : 0;
         o.retx_waiting = retx_ids.size() != 0;
         o.buffered_total = held_bytes;
         kind_seen[o.status]++;
         awaited.push_back(o);
      endfunction

      function void check_result(outcome_t got);
         outcome_t e;
         if (awaited.size() == 0) begin
            $error("result with no item outstanding");
            errors++;
            return;
         end
         e = awaited.pop_front();
         checked++;
         if (got.status !== e.status) begin
            $error("status exp %0d got %0d", e.status, got.status); errors++;
         end
         if (got.packet_id !== e.packet_id) begin
            $error("packet_id exp %0d got %0d", e.packet_id, got.packet_id); errors++;
         end
         if (got.ack_kind !== e.ack_kind) begin
            $error("ack_kind exp %0d got %0d", e.ack_kind, got.ack_kind); errors++;
         end
         if (got.moved_count !== e.moved_count) begin
            $error("moved_count exp %0d got %0d", e.moved_count, got.moved_count);
            errors++;
         end
         if (got.pending_front_id !== e.pending_front_id) begin
            $error("pending_front_id exp %0d got %0d", e.pending_front_id,
               got.pending_front_id); errors++;
         end
         if (got.sent_front_id !== e.sent_front_id) begin
            $error("sent_front_id exp %0d got %0d", e.sent_front_id, got.sent_front_id);
            errors++;
         end
         if (got.retx_waiting !== e.retx_waiting) begin
            $error("retx_waiting exp %0d got %0d", e.retx_waiting, got.retx_waiting);
            errors++;
         end
         if (got.buffered_total !== e.buffered_total) begin
            $error("buffered_total exp %0d got %0d", e.buffered_total,
               got.buffered_total); errors++;
         end
      endfunction
   endclass

   logic        clock;
   logic        reset;
   logic        start;
   logic        busy;
   logic [1:0]  req_action;
   logic [15:0] req_packet_bytes;
   logic [31:0] req_ack_id;
   logic        rsp_valid;
   logic [2:0]  rsp_status;
   logic [31:0] rsp_packet_id;
   logic [1:0]  rsp_ack_kind;
   logic [6:0]  rsp_moved_count;
   logic [31:0] rsp_pending_front_id;
   logic [31:0] rsp_sent_front_id;
   logic        rsp_retx_waiting;
   logic [23:0] rsp_buffered_total;
   logic        csr_we;
   logic [23:0] csr_wdata;

   tracker_board board;
   int idle_cycles;
   int watchdog_limit = 4000;
   logic timed_out;

   tx_buffer_ack_tracker_unit dut (.*);

   initial begin
      clock = 0;
      forever #10 clock = ~clock;
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         board.check_result({rsp_status, rsp_packet_id, rsp_ack_kind, rsp_moved_count,
            rsp_pending_front_id, rsp_sent_front_id, rsp_retx_waiting,
            rsp_buffered_total});
      end
   end

   always @(posedge clock) begin
      if (reset || rsp_valid || (start && !busy) || csr_we) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
   end

   initial begin
      timed_out = 0;
      wait (idle_cycles >= watchdog_limit);
      timed_out = 1;
      $display("tx_buffer_ack_tracker_unit regression: fail");
      $finish;
   end

   task automatic pause_random();
      int n;
      n = ($urandom_range(0, 19) == 0) ? $urandom_range(10, 60) : $urandom_range(0, 2);
      repeat (n) @(posedge clock);
   endtask

   task automatic issue(logic [1:0] act, logic [15:0] nbytes, logic [31:0] ack);
      start <= 1;
      req_action <= act;
      req_packet_bytes <= nbytes;
      req_ack_id <= ack;
      @(posedge clock);
      while (busy) @(posedge clock);
      board.note_item(act, nbytes, ack);
      start <= 0;
      @(posedge clock);
   endtask

   task automatic drain();
      while (board.awaited.size() != 0) @(posedge clock);
      repeat (140) @(posedge clock);
   endtask

   task automatic set_budget(logic [23:0] v);
      drain();
      csr_we <= 1;
      csr_wdata <= v;
      @(posedge clock);
      csr_we <= 0;
      board.budget = v;
   endtask

   function automatic logic [31:0] pick_ack();
      int r;
      int n;
      n = board.sent_ids.size();
      r = $urandom_range(0, 9);
      if (n == 0 || r == 0) return $urandom();
      if (r < 4) return board.sent_ids[0];
      if (r < 8) return board.sent_ids[$urandom_range(0, n - 1)];
      if (r == 8) return board.sent_ids[0] - 1;
      return board.sent_ids[n - 1] + $urandom_range(1, 3);
   endfunction

   task automatic random_phase(int count, int add_w, int send_w, int ack_w);
      int r;
      logic [15:0] nb;
      repeat (count) begin
         if ($urandom_range(0, 3) != 0) pause_random();
         r = $urandom_range(0, add_w + send_w + ack_w + 9);
         nb = ($urandom_range(0, 7) == 0) ? 16'($urandom()) : 16'($urandom_range(0, 300));
         if (r < add_w) issue(ACT_ADD, nb, $urandom());
         else if (r < add_w + send_w) issue(ACT_SEND, nb, $urandom());
         else if (r < add_w + send_w + ack_w) issue(ACT_ACK, nb, pick_ack());
         else issue(ACT_RETX, nb, $urandom());
      end
   endtask

   initial begin
      board = new();
      reset = 1;
      start = 0;
      req_action = ACT_ADD;
      req_packet_bytes = 0;
      req_ack_id = 0;
      csr_we = 0;
      csr_wdata = 0;
      repeat (9) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // empty queues and zero budget
      issue(ACT_SEND, 0, 0);
      issue(ACT_ACK, 0, 32'hFFFF_FFFF);
      issue(ACT_RETX, 16'hFFFF, 0);
      issue(ACT_ADD, 16'hFFFF, 0);
      issue(ACT_ADD, 0, 0);
      set_budget(24'hFFFFFF);
      issue(ACT_ADD, 16'hFFFF, 32'hFFFF_FFFF);
      issue(ACT_ADD, 16'h5555, 0);
      issue(ACT_ADD, 16'hAAAA, 0);
      issue(ACT_ADD, 1, 0);
      issue(ACT_SEND, 0, 0);
      issue(ACT_SEND, 0, 0);
      issue(ACT_SEND, 0, 0);
      issue(ACT_SEND, 0, 0);
      issue(ACT_ACK, 0, 0);
      issue(ACT_ACK, 0, 1);
      issue(ACT_ACK, 0, 4);
      issue(ACT_RETX, 0, 0);
      issue(ACT_RETX, 0, 0);
      issue(ACT_ADD, 7, 0);
      issue(ACT_SEND, 0, 0);
      issue(ACT_ACK, 0, 32'hFFFF_FFFF);
      issue(ACT_RETX, 0, 0);

      // full queues and retransmit overflow
      set_budget(24'd64);
      random_phase(150, 6, 1, 1);
      random_phase(250, 3, 3, 2);
      drain();
      set_budget(24'd5000);
      random_phase(350, 4, 3, 3);
      drain();
      set_budget(24'd300);
      random_phase(200, 4, 3, 3);
      set_budget(24'd0);
      random_phase(50, 4, 3, 3);
      set_budget(24'hFFFFFF);
      random_phase(550, 4, 3, 3);
      drain();

      $display("covered %0d items; status counts ok %0d buffull %0d empty %0d",
         board.checked, board.kind_seen[0], board.kind_seen[1], board.kind_seen[2]);
      $display("notfound %0d stale %0d qfull %0d, next id %0d", board.kind_seen[3],
         board.kind_seen[4], board.kind_seen[5], board.seq_no);
      if (board.errors == 0 && board.awaited.size() == 0)
         $display("tx_buffer_ack_tracker_unit regression: pass");
      else
         $display("tx_buffer_ack_tracker_unit regression: fail");
      $finish;
   end
endmodule

// ===== tx_buffer_ack_tracker_unit.f =====
design/tbat_pkg.sv
design/tbat_cell.sv
design/tx_buffer_ack_tracker_unit.sv
bench/tb_tx_buffer_ack_tracker_unit.sv
